@@ sv/two_class_fifo_oldest_first_assert.svh @@
// Assertion macros shared by the two-class FIFO RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef TWO_CLASS_FIFO_OLDEST_FIRST_ASSERT_SVH
`define TWO_CLASS_FIFO_OLDEST_FIRST_ASSERT_SVH
`ifndef SYNTH
`define TCFO_ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("tcfo assertion failed");
`define TCFO_ASSERT_IMPLY(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("tcfo assertion failed");
`else
`define TCFO_ASSERT_NEVER(name, clk, rst, expr)
`define TCFO_ASSERT_IMPLY(name, clk, rst, pre, post)
`endif
`endif

@@ sv/tcfo_pkg.sv @@
// Package for the two-class FIFO: widths, request and status codes, shared types.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package tcfo_pkg;

   localparam int ID_W            = 16;
   localparam int STAMP_W         = 6;
   localparam int QUEUE_DEPTH_DEF = 16;

   localparam logic [1:0] REQ_ENQ        = 2'd0;
   localparam logic [1:0] REQ_DEQ_ANY    = 2'd1;
   localparam logic [1:0] REQ_DEQ_FIRST  = 2'd2;
   localparam logic [1:0] REQ_DEQ_SECOND = 2'd3;

   localparam logic [1:0] STATUS_ENQ   = 2'd0;
   localparam logic [1:0] STATUS_DROP  = 2'd1;
   localparam logic [1:0] STATUS_DEQ   = 2'd2;
   localparam logic [1:0] STATUS_EMPTY = 2'd3;

   typedef enum logic [1:0] {
      OP_ENQ,
      OP_DEQ_ANY,
      OP_DEQ_CLASS
   } op_kind_type;

   typedef struct packed {
      op_kind_type       kind;
      logic              cls;
      logic [ID_W-1:0]   id;
   } op_type;

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctrl_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic last;
   } fifo_stat_type;

endpackage

@@ sv/tcfo_front.sv @@
// Front end: decodes each request into an operation and holds it in a two-entry queue.
// Depends on tcfo_pkg.
`timescale 1ns / 1ps

module tcfo_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_type,
   input  logic [tcfo_pkg::ID_W-1:0] req_item_id,
   input  logic                      req_item_class,
   output logic                      op_valid,
   output tcfo_pkg::op_type          op,
   input  logic                      op_take
);

   tcfo_pkg::op_type slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   tcfo_pkg::op_type decoded;
   logic             accept;
   logic             take;

   always_comb begin
      decoded.id  = req_item_id;
      decoded.cls = 1'b0;
      unique case (req_type)
         tcfo_pkg::REQ_ENQ: begin
            decoded.kind = tcfo_pkg::OP_ENQ;
            decoded.cls  = req_item_class;
         end
         tcfo_pkg::REQ_DEQ_ANY: begin
            decoded.kind = tcfo_pkg::OP_DEQ_ANY;
         end
         tcfo_pkg::REQ_DEQ_FIRST: begin
            decoded.kind = tcfo_pkg::OP_DEQ_CLASS;
         end
         tcfo_pkg::REQ_DEQ_SECOND: begin
            decoded.kind = tcfo_pkg::OP_DEQ_CLASS;
            decoded.cls  = 1'b1;
         end
         default: begin
            decoded.kind = tcfo_pkg::OP_DEQ_ANY;
         end
      endcase
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign accept    = req_valid && !req_stall;
   assign op_valid  = (cnt_ff != 2'd0);
   assign op        = slot_ff[rd_ptr_ff];
   assign take      = op_take && op_valid;

   always_comb begin
      wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, accept} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

@@ sv/tcfo_class_fifo.sv @@
// One class queue: id and stamp memory with head, tail and fill count.
// Depends on tcfo_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "two_class_fifo_oldest_first_assert.svh"

module tcfo_class_fifo #(
   parameter int DEPTH = tcfo_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tcfo_pkg::fifo_ctrl_type      ctrl,
   input  logic [tcfo_pkg::ID_W-1:0]    push_id,
   input  logic [tcfo_pkg::STAMP_W-1:0] push_stamp,
   output tcfo_pkg::fifo_stat_type      stat,
   output logic [tcfo_pkg::ID_W-1:0]    head_id,
   output logic [tcfo_pkg::STAMP_W-1:0] head_stamp
);

   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = tcfo_pkg::ID_W + tcfo_pkg::STAMP_W;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_ff;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctrl.push) begin
         tail_in = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
      end
      if (ctrl.pop) begin
         head_in = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(ctrl.push) - CNT_W'(ctrl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[tail_ff] <= {push_id, push_stamp};
      end
      rd_ff <= mem[head_ff];
   end

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == FULL_CNT);
   assign stat.last  = (count_ff == CNT_W'(1));
   assign head_id    = rd_ff[WORD_W-1:tcfo_pkg::STAMP_W];
   assign head_stamp = rd_ff[tcfo_pkg::STAMP_W-1:0];

   `TCFO_ASSERT_NEVER(a_push_full, clock, reset, ctrl.push && stat.full)
   `TCFO_ASSERT_NEVER(a_pop_empty, clock, reset, ctrl.pop && stat.empty)
   `TCFO_ASSERT_IMPLY(a_empty_ptrs, clock, reset, count_ff == '0, head_ff == tail_ff)
   `TCFO_ASSERT_NEVER(a_count_range, clock, reset, count_ff > FULL_CNT)

endmodule

@@ sv/tcfo_back.sv @@
// Back end: carries out queued operations on the two class queues and holds the result.
// Depends on tcfo_pkg and tcfo_class_fifo.
`timescale 1ns / 1ps

module tcfo_back #(
   parameter int QUEUE_DEPTH = tcfo_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      op_valid,
   input  tcfo_pkg::op_type          op,
   output logic                      op_take,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [tcfo_pkg::ID_W-1:0] rsp_out_id,
   output logic                      rsp_out_class
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_DEQ  = 1'b1;

   logic                         state_ff, state_in;
   logic                         deq_any_ff, deq_any_in;
   logic                         deq_cls_ff, deq_cls_in;
   logic [tcfo_pkg::STAMP_W-1:0] stamp_ff, stamp_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [1:0]                   status_ff, status_in;
   logic [tcfo_pkg::ID_W-1:0]    out_id_ff, out_id_in;
   logic                         out_class_ff, out_class_in;

   tcfo_pkg::fifo_ctrl_type      ctrl0, ctrl1;
   tcfo_pkg::fifo_stat_type      stat0, stat1;
   logic [tcfo_pkg::ID_W-1:0]    head_id0, head_id1;
   logic [tcfo_pkg::STAMP_W-1:0] head_stamp0, head_stamp1;
   logic [tcfo_pkg::STAMP_W-1:0] next_stamp;
   logic [tcfo_pkg::STAMP_W-1:0] stamp_diff;
   logic                         out_free;
   logic                         sel;
   logic                         sel_empty;
   logic                         enq_full;

   tcfo_class_fifo #(.DEPTH(QUEUE_DEPTH)) u_first (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl0),
      .push_id    (op.id),
      .push_stamp (next_stamp),
      .stat       (stat0),
      .head_id    (head_id0),
      .head_stamp (head_stamp0)
   );

   tcfo_class_fifo #(.DEPTH(QUEUE_DEPTH)) u_second (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl1),
      .push_id    (op.id),
      .push_stamp (next_stamp),
      .stat       (stat1),
      .head_id    (head_id1),
      .head_stamp (head_stamp1)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign next_stamp = stamp_ff + 1'b1;
   assign stamp_diff = head_stamp1 - head_stamp0;
   assign enq_full   = op.cls ? stat1.full : stat0.full;

   // The first class head is older when the modular distance is in the lower half, not zero.
   always_comb begin
      if (!deq_any_ff) begin
         sel = deq_cls_ff;
      end else if (stat0.empty) begin
         sel = 1'b1;
      end else if (stat1.empty) begin
         sel = 1'b0;
      end else begin
         sel = !((stamp_diff != '0) && !stamp_diff[tcfo_pkg::STAMP_W-1]);
      end
      sel_empty = sel ? stat1.empty : stat0.empty;
   end

   always_comb begin
      state_in     = state_ff;
      deq_any_in   = deq_any_ff;
      deq_cls_in   = deq_cls_ff;
      stamp_in     = stamp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      out_id_in    = out_id_ff;
      out_class_in = out_class_ff;
      ctrl0        = '0;
      ctrl1        = '0;
      op_take      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (op_valid && out_free) begin
               op_take = 1'b1;
               if (op.kind == tcfo_pkg::OP_ENQ) begin
                  rsp_valid_in = 1'b1;
                  out_id_in    = '0;
                  out_class_in = 1'b0;
                  if (enq_full) begin
                     status_in = tcfo_pkg::STATUS_DROP;
                  end else begin
                     status_in  = tcfo_pkg::STATUS_ENQ;
                     stamp_in   = next_stamp;
                     ctrl0.push = !op.cls;
                     ctrl1.push = op.cls;
                  end
               end else begin
                  deq_any_in = (op.kind == tcfo_pkg::OP_DEQ_ANY);
                  deq_cls_in = op.cls;
                  state_in   = S_DEQ;
               end
            end
         end
         S_DEQ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (sel_empty) begin
                  status_in    = tcfo_pkg::STATUS_EMPTY;
                  out_id_in    = '0;
                  out_class_in = 1'b0;
               end else begin
                  status_in    = tcfo_pkg::STATUS_DEQ;
                  out_id_in    = sel ? head_id1 : head_id0;
                  out_class_in = sel;
                  ctrl0.pop    = !sel;
                  ctrl1.pop    = sel;
                  if ((sel ? stat1.last : stat0.last) && (sel ? stat0.empty : stat1.empty)) begin
                     stamp_in = '0;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stamp_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stamp_ff     <= stamp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      deq_any_ff   <= deq_any_in;
      deq_cls_ff   <= deq_cls_in;
      status_ff    <= status_in;
      out_id_ff    <= out_id_in;
      out_class_ff <= out_class_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_out_id    = out_id_ff;
   assign rsp_out_class = out_class_ff;

endmodule

@@ sv/two_class_fifo_oldest_first.sv @@
// Path: an enqueue passes the front-end slot and then the result registers; a dequeue also
// passes the S_DEQ state. Throughput: one enqueue per cycle unless the response stalls; a dequeue
// holds the back end in S_DEQ, as the head entries come out of the class memories through a registered read port.
// Reset: synchronous; clears pointers, counts, stamp and handshake state. The memories are
// not cleared, so requests are accepted from the first cycle after reset.
`timescale 1ns / 1ps

module two_class_fifo_oldest_first #(
   parameter int QUEUE_DEPTH = tcfo_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_type,
   input  logic [tcfo_pkg::ID_W-1:0] req_item_id,
   input  logic                      req_item_class,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [tcfo_pkg::ID_W-1:0] rsp_out_id,
   output logic                      rsp_out_class
);

   logic             op_valid;
   logic             op_take;
   tcfo_pkg::op_type op;

   tcfo_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_item_id    (req_item_id),
      .req_item_class (req_item_class),
      .op_valid       (op_valid),
      .op             (op),
      .op_take        (op_take)
   );

   tcfo_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock         (clock),
      .reset         (reset),
      .op_valid      (op_valid),
      .op            (op),
      .op_take       (op_take),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_out_id    (rsp_out_id),
      .rsp_out_class (rsp_out_class)
   );

endmodule
